// ===== src/debounced_power_mode_select_macros.svh =====
// assertion macros shared by the debounced power mode select block
`ifndef DEBOUNCED_POWER_MODE_SELECT_MACROS_SVH
`define DEBOUNCED_POWER_MODE_SELECT_MACROS_SVH

// generic clocked assertion with explicit clock and active-low reset
`define DPMS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the block's own clock and reset
`define DPMS_ASSERT(lbl, prop, msg) \
  `DPMS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/dpms_pkg.sv =====
// types, codes and helpers for the debounced power mode select block
package dpms_pkg;

  localparam int unsigned TIME_W = 32;

  // item kinds
  typedef enum logic [1:0] {
    REQ_PREF  = 2'd0,
    REQ_SAVER = 2'd1,
    REQ_BATT  = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  // preference codes; the fourth code behaves as off
  localparam logic [1:0] PREF_OFF  = 2'd0;
  localparam logic [1:0] PREF_ON   = 2'd1;
  localparam logic [1:0] PREF_AUTO = 2'd2;

  typedef struct packed {
    logic [1:0]        pref;
    logic              saver;
    logic              batt;
    logic              active;
    logic              pend_valid;
    logic              pend_mode;
    logic [TIME_W-1:0] pend_start;
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        pref_value;
    logic              signal_level;
    logic [TIME_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic mode_active;
    logic mode_changed;
  } result_t;

  localparam state_t STATE_RESET = '{
    pref:       PREF_AUTO,
    saver:      1'b0,
    batt:       1'b0,
    active:     1'b0,
    pend_valid: 1'b0,
    pend_mode:  1'b0,
    pend_start: '0
  };

  // mode wanted by a preference and the two signals
  function automatic logic dpms_target(logic [1:0] pref, logic saver, logic batt);
    logic t;
    if (pref == PREF_ON) begin
      t = 1'b1;
    end else if (pref == PREF_AUTO) begin
      t = saver | batt;
    end else begin
      t = 1'b0;
    end
    return t;
  endfunction

endpackage

// ===== src/dpms_core.sv =====
// next-state and result logic for one item of the power mode selector
module dpms_core
  import dpms_pkg::*;
(
  input  state_t            state_i,
  input  item_t             item_i,
  input  logic [TIME_W-1:0] debounce_time_i,
  output state_t            state_o,
  output result_t           result_o
);

  logic              want;
  logic              changed;
  logic [TIME_W-1:0] elapsed;
  state_t            sig_st;

  // wrap-around elapsed time since the debounce was armed
  assign elapsed = item_i.now_time - state_i.pend_start;

  always_comb begin
    state_o = state_i;
    changed = 1'b0;
    want    = 1'b0;
    sig_st  = state_i;
    unique case (req_e'(item_i.req_type))
      REQ_PREF: begin
        // new preference commits its target at once
        state_o.pref       = item_i.pref_value;
        state_o.pend_valid = 1'b0;
        want               = dpms_target(item_i.pref_value, state_i.saver, state_i.batt);
        changed            = (want != state_i.active);
        state_o.active     = want;
      end
      REQ_SAVER, REQ_BATT: begin
        // store the signal level, then re-evaluate the debounce
        if (req_e'(item_i.req_type) == REQ_SAVER) begin
          sig_st.saver = item_i.signal_level;
        end else begin
          sig_st.batt = item_i.signal_level;
        end
        state_o = sig_st;
        want    = dpms_target(sig_st.pref, sig_st.saver, sig_st.batt);
        if (sig_st.pref != PREF_AUTO || want == sig_st.active) begin
          state_o.pend_valid = 1'b0;
        end else if (!sig_st.pend_valid || sig_st.pend_mode != want) begin
          state_o.pend_valid = 1'b1;
          state_o.pend_mode  = want;
          state_o.pend_start = item_i.now_time;
        end
      end
      REQ_TICK: begin
        // commit the pending mode once the interval has passed
        if (state_i.pend_valid && elapsed >= debounce_time_i) begin
          state_o.pend_valid = 1'b0;
          changed            = (state_i.pend_mode != state_i.active);
          state_o.active     = state_i.pend_mode;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.mode_active  = state_o.active;
  assign result_o.mode_changed = changed;

endmodule

// ===== src/debounced_power_mode_select.sv =====
// top level of the debounced power mode selector: item register, state and result register
// order: an accepted item is held in the item register, and the result register loads its
//   result when that register is free or being drained, so an output stall holds it back
// throughput: one item per cycle while the output is not stalled; the state update and
//   result load share one edge, so each item sees the state left by the one before it
// reset: rst_ni low clears state to preference auto, signals, mode and debounce to zero,
//   debounce interval to zero, and empties the item and result registers
`include "debounced_power_mode_select_macros.svh"

module debounced_power_mode_select
  import dpms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [1:0]        pref_value_i,
  input  logic              signal_level_i,
  input  logic [TIME_W-1:0] now_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              mode_active_o,
  output logic              mode_changed_o
);

  logic [TIME_W-1:0] debounce_q;
  logic              s1_valid_q;
  item_t             s1_item_q;
  state_t            st_q, st_d;
  result_t           res_d, res_q;
  logic              out_valid_q;
  logic              s1_fire;
  logic              in_fire;

  // item moves on when the result register is free or being drained
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // debounce interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= '0;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{req_type: req_type_i, pref_value: pref_value_i,
                     signal_level: signal_level_i, now_time: now_time_i};
    end
  end

  dpms_core u_core (
    .state_i         (st_q),
    .item_i          (s1_item_q),
    .debounce_time_i (debounce_q),
    .state_o         (st_d),
    .result_o        (res_d)
  );

  // selector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_active_o  = res_q.mode_active;
  assign mode_changed_o = res_q.mode_changed;

  // checks
  `DPMS_ASSERT(a_pend_only_auto, st_q.pend_valid |-> (st_q.pref == PREF_AUTO), "pending change outside auto")
  `DPMS_ASSERT(a_pend_differs, st_q.pend_valid |-> (st_q.pend_mode != st_q.active), "pending mode equals active mode")
  `DPMS_ASSERT(a_changed_toggles, (s1_fire && res_d.mode_changed) |=> (st_q.active != $past(st_q.active)), "change flag without mode toggle")
  `DPMS_ASSERT(a_state_holds, !s1_fire |=> $stable(st_q), "state moved without an item")
  `DPMS_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready_o, "input stalled with empty output")

endmodule
